FILE: rtl/scsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, constants and class tables of the size class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int NUM_ARENAS   = 64;
  localparam int ARENA_W      = 6;
  localparam int AREF_W       = 7;   // arena id or nil
  localparam int BLOCK_W      = 8;
  localparam int CLASS_W      = 5;
  localparam int CLASS_COUNT  = 31;
  localparam int LIMIT_W      = 7;

  localparam logic [AREF_W-1:0]  ARENA_NIL  = AREF_W'(NUM_ARENAS);
  localparam logic [BLOCK_W-1:0] LINK_END   = 8'd255;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = LIMIT_W'(NUM_ARENAS);
  // data offset = arena header (40) + block header (8) + block * class bytes
  localparam logic [11:0]        OFFSET_BASE = 12'd48;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_ZERO     = 3'd1,
    ST_LARGE    = 3'd2,
    ST_NO_ARENA = 3'd3,
    ST_FREED    = 3'd4,
    ST_RELEASED = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  // one arena descriptor as held in the arena table
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [BLOCK_W-1:0] used;
    logic [BLOCK_W-1:0] head;
    logic [AREF_W-1:0]  nxt;
    logic [AREF_W-1:0]  prv;
  } arena_ent_t;

  localparam arena_ent_t ENT_RESET = '{cls: '0, used: '0, head: '0,
                                       nxt: ARENA_NIL, prv: ARENA_NIL};

  function automatic logic [9:0] class_bytes(input logic [CLASS_W-1:0] c);
    logic [9:0] r;
    case (c)
      5'd0:  r = 10'd16;   5'd1:  r = 10'd24;   5'd2:  r = 10'd32;
      5'd3:  r = 10'd40;   5'd4:  r = 10'd48;   5'd5:  r = 10'd56;
      5'd6:  r = 10'd64;   5'd7:  r = 10'd72;   5'd8:  r = 10'd80;
      5'd9:  r = 10'd88;   5'd10: r = 10'd96;   5'd11: r = 10'd104;
      5'd12: r = 10'd112;  5'd13: r = 10'd120;  5'd14: r = 10'd128;
      5'd15: r = 10'd144;  5'd16: r = 10'd160;  5'd17: r = 10'd176;
      5'd18: r = 10'd192;  5'd19: r = 10'd208;  5'd20: r = 10'd224;
      5'd21: r = 10'd240;  5'd22: r = 10'd256;  5'd23: r = 10'd288;
      5'd24: r = 10'd320;  5'd25: r = 10'd352;  5'd26: r = 10'd384;
      5'd27: r = 10'd416;  5'd28: r = 10'd448;  5'd29: r = 10'd480;
      5'd30: r = 10'd512;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // blocks per arena: 4056 usable bytes / class bytes
  function automatic logic [BLOCK_W-1:0] class_blocks(input logic [CLASS_W-1:0] c);
    logic [BLOCK_W-1:0] r;
    case (c)
      5'd0:  r = 8'd253;  5'd1:  r = 8'd169;  5'd2:  r = 8'd126;
      5'd3:  r = 8'd101;  5'd4:  r = 8'd84;   5'd5:  r = 8'd72;
      5'd6:  r = 8'd63;   5'd7:  r = 8'd56;   5'd8:  r = 8'd50;
      5'd9:  r = 8'd46;   5'd10: r = 8'd42;   5'd11: r = 8'd39;
      5'd12: r = 8'd36;   5'd13: r = 8'd33;   5'd14: r = 8'd31;
      5'd15: r = 8'd28;   5'd16: r = 8'd25;   5'd17: r = 8'd23;
      5'd18: r = 8'd21;   5'd19: r = 8'd19;   5'd20: r = 8'd18;
      5'd21: r = 8'd16;   5'd22: r = 8'd15;   5'd23: r = 8'd14;
      5'd24: r = 8'd12;   5'd25: r = 8'd11;   5'd26: r = 8'd10;
      5'd27: r = 8'd9;    5'd28: r = 8'd9;    5'd29: r = 8'd8;
      5'd30: r = 8'd7;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/scsa_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_link_ram
// Free list links, one 256-entry row per arena, registered read.
// ----------------------------------------------------------------------------
module scsa_link_ram (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [scsa_pkg::ARENA_W+scsa_pkg::BLOCK_W-1:0] waddr,
  input  logic [scsa_pkg::BLOCK_W-1:0]                wdata,
  input  logic [scsa_pkg::ARENA_W+scsa_pkg::BLOCK_W-1:0] raddr,
  output logic [scsa_pkg::BLOCK_W-1:0]                rdata
);
  import scsa_pkg::*;

  logic [BLOCK_W-1:0] mem [NUM_ARENAS*256];
  logic [BLOCK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/scsa_arena_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsa_arena_ram
// Arena descriptor table with registered read; unwritten entries read as
// the reset descriptor.
// ----------------------------------------------------------------------------
module scsa_arena_ram (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [scsa_pkg::ARENA_W-1:0] waddr,
  input  scsa_pkg::arena_ent_t         wdata,
  input  logic [scsa_pkg::ARENA_W-1:0] raddr,
  output scsa_pkg::arena_ent_t         rdata
);
  import scsa_pkg::*;

  arena_ent_t            mem [NUM_ARENAS];
  arena_ent_t            q_r;
  logic [NUM_ARENAS-1:0] vld_r;
  logic                  q_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : ENT_RESET;

endmodule

FILE: rtl/size_class_slab_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Slab allocator over 64 arenas of 4 KiB with 31 size classes.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on the in_ ports and raise start; it is taken at a clock
//   edge where busy is low. in_req_type 0 allocates in_request_bytes, 1 frees
//   block in_free_block of arena in_free_arena.
//   Exactly one result per item appears on the out_ ports for one cycle with
//   out_valid high; the receiver cannot stall it, so it must take it then.
//   cfg_we writes cfg_wdata as arena limit; use only while idle (unchecked).
// Steps (one item at a time):
//   zero, large, no-arena results and a free of an arena not in use: S_DEC;
//   a free with a block index out of range: S_DEC, S_F_LD.
//   allocation from a listed arena: S_DEC, S_A_LD, S_POP, S_P_LK, S_WB;
//   S_REM unlinks the arena from its class list first when it fills up.
//   allocation that claims a new arena: S_DEC, then S_INIT, the pass
//   that writes the arena's 256 free list links, one per cycle; then S_POP.
//   free: S_DEC, S_F_LD, S_F_DEC, S_WB; S_RD_X, S_WR_X relink a full arena,
//   S_REM unlinks a released one. busy drops with out_valid, and the next
//   item can follow. Steps read and write the arena table and link memory.
// Reset: synchronous; clears arena pool and class lists, sets limit to 64.
// ----------------------------------------------------------------------------
module size_class_slab_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_request_bytes,
  input  logic [5:0]  in_free_arena,
  input  logic [7:0]  in_free_block,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_arena,
  output logic [7:0]  out_block,
  output logic [4:0]  out_size_class,
  output logic [9:0]  out_class_bytes,
  output logic [11:0] out_arena_offset,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);
  import scsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_INIT, S_A_LD, S_POP, S_P_LK, S_F_LD, S_F_DEC,
    S_REM, S_REM2, S_REM3, S_RD_X, S_WR_X, S_WB
  } state_t;

  typedef enum logic {FLD_NXT, FLD_PRV} fld_t;

  state_t                state_r, ret_r;
  logic                  in_req_r;
  logic [31:0]           in_bytes_r;
  logic [ARENA_W-1:0]    in_farena_r;
  logic [BLOCK_W-1:0]    in_fblock_r;
  logic [ARENA_W-1:0]    a_r, x_r;
  logic [BLOCK_W-1:0]    b_r, idx_r, nb_r;
  logic [CLASS_W-1:0]    c_r;
  logic [9:0]            bs_r;
  arena_ent_t            ent_r;
  fld_t                  xsel_r;
  logic [AREF_W-1:0]     xval_r, p_r, n_r;
  status_t               st_r;
  logic [AREF_W-1:0]     head_tab_r [CLASS_COUNT];
  logic [NUM_ARENAS-1:0] in_use_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [5:0]            out_arena_r;
  logic [7:0]            out_block_r;
  logic [4:0]            out_class_r;
  logic [9:0]            out_bytes_r;
  logic [11:0]           out_offset_r;

  // request decode
  logic               req_zero, req_large;
  logic [9:0]         tot_a, tot;
  logic [10:0]        cls_w;
  logic [CLASS_W-1:0] cls_dec;
  logic [AREF_W-1:0]  head_a;
  logic [LIMIT_W-1:0] lim;
  logic               ffound;
  logic [ARENA_W-1:0] fidx;
  // free decode
  arena_ent_t         ar_rdata, ar_wdata, fld_ent, patch_ent;
  logic [CLASS_W-1:0] f_c;
  logic [BLOCK_W-1:0] f_nb;
  logic               f_ok, f_ins, f_rmw;
  logic [AREF_W-1:0]  f_h;
  logic [BLOCK_W-1:0] used_inc, used_dec;
  // memory ports
  logic               ar_we;
  logic [ARENA_W-1:0] ar_waddr, ar_raddr;
  logic               lk_we;
  logic [ARENA_W+BLOCK_W-1:0] lk_waddr, lk_raddr;
  logic [BLOCK_W-1:0] lk_wdata, lk_rdata;
  logic [BLOCK_W:0]   idx_inc;
  logic [17:0]        prod;

  always_comb begin
    req_zero = (in_bytes_r == 32'd0);
    req_large = (in_bytes_r > 32'd504);
    tot_a = {1'b0, in_bytes_r[8:0]} + 10'd7;
    tot = {tot_a[9:3], 3'b000} + 10'd8;
    if (tot <= 10'd16) begin
      cls_w = '0;
    end else if (tot <= 10'd128) begin
      cls_w = {4'b0, tot[9:3]} - 11'd2;
    end else if (tot <= 10'd256) begin
      cls_w = (({1'b0, tot} + 11'd15) >> 4) + 11'd6;
    end else begin
      cls_w = (({1'b0, tot} + 11'd31) >> 5) + 11'd14;
    end
    cls_dec = cls_w[CLASS_W-1:0];
    head_a = head_tab_r[cls_dec];

    lim = (limit_r > LIMIT_MAX) ? LIMIT_MAX : limit_r;
    ffound = 1'b0;
    fidx = '0;
    // lowest unused id below the limit
    for (int i = NUM_ARENAS - 1; i >= 0; i--) begin
      if (!in_use_r[i] && (LIMIT_W'(i) < lim)) begin
        ffound = 1'b1;
        fidx = ARENA_W'(i);
      end
    end
  end

  always_comb begin
    f_c = (ar_rdata.cls == 5'd31) ? 5'd0 : ar_rdata.cls;
    f_nb = class_blocks(f_c);
    f_ok = (b_r < f_nb);
    f_ins = (ar_rdata.used >= f_nb);
    f_h = head_tab_r[f_c];
    f_rmw = f_ins && (f_h < ARENA_NIL) && (f_h != {1'b0, a_r});
    fld_ent = ar_rdata;
    fld_ent.head = b_r;
    if (f_ins) begin
      // relist a full arena at the head of its class
      fld_ent.nxt = f_h;
      fld_ent.prv = (f_h == {1'b0, a_r}) ? {1'b0, a_r} : ARENA_NIL;
    end
    patch_ent = ar_rdata;
    if (xsel_r == FLD_NXT) begin
      patch_ent.nxt = xval_r;
    end else begin
      patch_ent.prv = xval_r;
    end
    used_inc = ent_r.used + 8'd1;
    used_dec = (ent_r.used != 8'd0) ? ent_r.used - 8'd1 : ent_r.used;
    idx_inc = {1'b0, idx_r} + 9'd1;
    prod = b_r * bs_r;
  end

  always_comb begin
    case (state_r)
      S_DEC:   ar_raddr = in_req_r ? in_farena_r : head_a[ARENA_W-1:0];
      S_RD_X:  ar_raddr = x_r;
      default: ar_raddr = a_r;
    endcase
    ar_we = (state_r == S_WR_X) || (state_r == S_WB);
    ar_waddr = (state_r == S_WR_X) ? x_r : a_r;
    ar_wdata = (state_r == S_WR_X) ? patch_ent : ent_r;

    lk_we = (state_r == S_INIT) || ((state_r == S_F_LD) && f_ok);
    if (state_r == S_INIT) begin
      lk_waddr = {a_r, idx_r};
      lk_wdata = (idx_inc < {1'b0, nb_r}) ? idx_inc[BLOCK_W-1:0] : LINK_END;
    end else begin
      lk_waddr = {a_r, b_r};
      lk_wdata = ar_rdata.head;
    end
    lk_raddr = {a_r, ent_r.head};
  end

  scsa_arena_ram u_arena_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ar_we),
    .waddr (ar_waddr),
    .wdata (ar_wdata),
    .raddr (ar_raddr),
    .rdata (ar_rdata)
  );

  scsa_link_ram u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_MAX;
      in_use_r    <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head_tab_r[i] <= ARENA_NIL;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_req_r    <= in_req_type;
            in_bytes_r  <= in_request_bytes;
            in_farena_r <= in_free_arena;
            in_fblock_r <= in_free_block;
            state_r     <= S_DEC;
          end
        end
        S_DEC: begin
          out_arena_r  <= '0;
          out_block_r  <= '0;
          out_class_r  <= '0;
          out_bytes_r  <= '0;
          out_offset_r <= '0;
          if (in_req_r) begin
            a_r <= in_farena_r;
            b_r <= in_fblock_r;
            if (!in_use_r[in_farena_r]) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_INVALID;
              state_r      <= S_IDLE;
            end else begin
              state_r <= S_F_LD;
            end
          end else if (req_zero || req_large) begin
            out_valid_r  <= 1'b1;
            out_status_r <= req_zero ? ST_ZERO : ST_LARGE;
            state_r      <= S_IDLE;
          end else begin
            c_r  <= cls_dec;
            nb_r <= class_blocks(cls_dec);
            bs_r <= class_bytes(cls_dec);
            if (head_a != ARENA_NIL) begin
              a_r     <= head_a[ARENA_W-1:0];
              state_r <= S_A_LD;
            end else if (ffound) begin
              a_r     <= fidx;
              idx_r   <= '0;
              state_r <= S_INIT;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_NO_ARENA;
              state_r      <= S_IDLE;
            end
          end
        end
        S_INIT: begin
          idx_r <= idx_inc[BLOCK_W-1:0];
          if (idx_r == LINK_END) begin
            in_use_r[a_r]   <= 1'b1;
            ent_r           <= '{cls: c_r, used: '0, head: '0,
                                 nxt: ARENA_NIL, prv: ARENA_NIL};
            head_tab_r[c_r] <= {1'b0, a_r};
            state_r         <= S_POP;
          end
        end
        S_A_LD: begin
          ent_r   <= ar_rdata;
          state_r <= S_POP;
        end
        S_POP: begin
          b_r     <= ent_r.head;
          state_r <= S_P_LK;
        end
        S_P_LK: begin
          ent_r.head <= lk_rdata;
          ent_r.used <= used_inc;
          st_r       <= ST_ALLOC;
          state_r    <= (used_inc >= nb_r) ? S_REM : S_WB;
        end
        S_F_LD: begin
          if (!f_ok) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_INVALID;
            state_r      <= S_IDLE;
          end else begin
            c_r   <= f_c;
            nb_r  <= f_nb;
            ent_r <= fld_ent;
            if (f_ins) begin
              head_tab_r[f_c] <= {1'b0, a_r};
            end
            if (f_rmw) begin
              x_r     <= f_h[ARENA_W-1:0];
              xsel_r  <= FLD_PRV;
              xval_r  <= {1'b0, a_r};
              ret_r   <= S_F_DEC;
              state_r <= S_RD_X;
            end else begin
              state_r <= S_F_DEC;
            end
          end
        end
        S_F_DEC: begin
          ent_r.used <= used_dec;
          if (used_dec == 8'd0) begin
            st_r          <= ST_RELEASED;
            ent_r.cls     <= '0;
            ent_r.head    <= '0;
            in_use_r[a_r] <= 1'b0;
            state_r       <= S_REM;
          end else begin
            st_r    <= ST_FREED;
            state_r <= S_WB;
          end
        end
        // unlink arena a_r from its class list
        S_REM: begin
          p_r <= ent_r.prv;
          n_r <= ent_r.nxt;
          if (ent_r.prv < ARENA_NIL) begin
            x_r     <= ent_r.prv[ARENA_W-1:0];
            xsel_r  <= FLD_NXT;
            xval_r  <= ent_r.nxt;
            ret_r   <= S_REM2;
            state_r <= S_RD_X;
          end else begin
            if (head_tab_r[c_r] == {1'b0, a_r}) begin
              head_tab_r[c_r] <= ent_r.nxt;
            end
            state_r <= S_REM2;
          end
        end
        S_REM2: begin
          if (n_r < ARENA_NIL) begin
            x_r     <= n_r[ARENA_W-1:0];
            xsel_r  <= FLD_PRV;
            xval_r  <= p_r;
            ret_r   <= S_REM3;
            state_r <= S_RD_X;
          end else begin
            state_r <= S_REM3;
          end
        end
        S_REM3: begin
          ent_r.nxt <= ARENA_NIL;
          ent_r.prv <= ARENA_NIL;
          state_r   <= S_WB;
        end
        S_RD_X: state_r <= S_WR_X;
        S_WR_X: state_r <= ret_r;
        S_WB: begin
          out_valid_r  <= 1'b1;
          out_status_r <= st_r;
          if (st_r == ST_ALLOC) begin
            out_arena_r  <= a_r;
            out_block_r  <= b_r;
            out_class_r  <= c_r;
            out_bytes_r  <= bs_r;
            out_offset_r <= OFFSET_BASE + prod[11:0];
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_arena        = out_arena_r;
  assign out_block        = out_block_r;
  assign out_size_class   = out_class_r;
  assign out_class_bytes  = out_bytes_r;
  assign out_arena_offset = out_offset_r;

`ifndef SYNTHESIS
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  a_claim_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_use_r[a_r])
    else $error("claiming an arena already in use");

  a_alloc_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ALLOC)) |-> in_use_r[out_arena])
    else $error("allocated from an arena not in use");
`endif

endmodule
